// ----- sv/bbl_pkg.sv -----
// Shared constants, types and record layout for the 3x3 box blur.
package bbl_pkg;

	localparam int FRAME_WIDTH  = 256;
	localparam int FRAME_HEIGHT = 256;

	localparam int XW = $clog2(FRAME_WIDTH);
	localparam int YW = $clog2(FRAME_HEIGHT);

	// Record queue between front and back
	localparam int QDEPTH = 8;
	localparam int QAW    = $clog2(QDEPTH);

	// Divide by nine: multiply by a rounded-up reciprocal and shift
	localparam int DIV_SH  = 16;
	localparam int DIV_MUL = (2 ** DIV_SH + 8) / 9;

	// Result kinds, in emission order
	localparam int RES_INNER  = 0;
	localparam int RES_RIM    = 1;
	localparam int RES_BOTTOM = 2;
	localparam int RES_N      = 3;

	typedef logic [23:0]   pix_t;
	typedef logic [XW-1:0] xcnt_t;
	typedef logic [YW-1:0] ycnt_t;
	typedef logic [QAW:0]  qlvl_t;

	localparam xcnt_t X_LAST = xcnt_t'(FRAME_WIDTH - 1);
	localparam ycnt_t Y_LAST = ycnt_t'(FRAME_HEIGHT - 1);

	typedef struct packed {
		logic [RES_N-1:0] kinds;
		logic [7:0]       x;
		logic [7:0]       y;
		pix_t             inner_pix;
		pix_t             rim_pix;
		pix_t             cur_pix;
	} rec_t;

endpackage

// ----- sv/box_blur_three_by_three_top.sv -----
// 3x3 box blur top level: streams RGB pixels in raster order, emits coordinate-tagged results.
// Each result passes the s1 and s2 registers, the record queue and the output register.
// Throughput: one pixel per cycle unless in_stall; the output side drains one result per cycle
// unless out_stall, and an 8-record queue absorbs the up-to-three results at row ends.
// Reset (arst_n low) clears counters, window, pipeline valids and queue; line memory is
// not cleared and its contents only reach a result once written.
module box_blur_three_by_three_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_x,
	output logic [7:0] out_y,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic       last_of_run
);
	import bbl_pkg::*;

	logic  push;
	rec_t  push_rec;
	logic  pop;
	rec_t  head;
	logic  not_empty;
	qlvl_t level;

	bbl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.q_level  (level),
		.push     (push),
		.push_rec (push_rec)
	);

	bbl_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.level     (level)
	);

	bbl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.not_empty   (not_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.last_of_run (last_of_run)
	);

endmodule

// ----- sv/bbl_front.sv -----
// Front end: pixel counters, line memory, column window and blur arithmetic.
module bbl_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    red,
	input  logic [7:0]    green,
	input  logic [7:0]    blue,
	input  bbl_pkg::qlvl_t q_level,
	output logic          push,
	output bbl_pkg::rec_t push_rec
);
	import bbl_pkg::*;

	localparam int LW = QAW + 2;

	logic        acc;
	xcnt_t       x_q;
	ycnt_t       y_q;

	logic [47:0] line_mem [FRAME_WIDTH];

	logic        v_s1;
	xcnt_t       x_s1;
	ycnt_t       y_s1;
	pix_t        cur_s1;
	logic [47:0] line_rd_s1;

	pix_t        win_q [6];

	logic        v_s2;
	logic [RES_N-1:0] kinds_s2;
	logic [7:0]  x8_s2;
	logic [7:0]  y8_s2;
	logic [11:0] sum_s2 [3];
	logic        blur_s2;
	pix_t        pass_s2;
	pix_t        mid_s2;
	pix_t        cur_s2;

	pix_t        top;
	pix_t        mid;
	logic [11:0] sum_c [3];
	logic [RES_N-1:0] kinds;
	logic        y_ge2;
	logic [24:0] prod [3];
	pix_t        quot;

	// Hold input while the queue could not take every item in flight
	assign in_stall = (LW'(q_level) + LW'(v_s1) + LW'(v_s2)) >= LW'(QDEPTH);
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			y_q  <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			if (acc) begin
				if (x_q == X_LAST) begin
					x_q <= '0;
					y_q <= (y_q == Y_LAST) ? '0 : y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			if (v_s1) begin
				win_q[3] <= win_q[0];
				win_q[4] <= win_q[1];
				win_q[5] <= win_q[2];
				win_q[0] <= top;
				win_q[1] <= mid;
				win_q[2] <= cur_s1;
			end
		end
	end

	// Read the column at accept, write it back in the cycle after
	always_ff @(posedge clk) begin
		if (acc) begin
			line_rd_s1 <= line_mem[x_q];
			x_s1       <= x_q;
			y_s1       <= y_q;
			cur_s1     <= {red, green, blue};
		end
		if (v_s1) line_mem[x_s1] <= {mid, cur_s1};
	end

	assign top = line_rd_s1[47:24];
	assign mid = line_rd_s1[23:0];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_c[c] = 12'(win_q[3][8*c +: 8]) + 12'(win_q[0][8*c +: 8]) + 12'(top[8*c +: 8])
				+ 12'(win_q[4][8*c +: 8]) + 12'(win_q[1][8*c +: 8]) + 12'(mid[8*c +: 8])
				+ 12'(win_q[5][8*c +: 8]) + 12'(win_q[2][8*c +: 8]) + 12'(cur_s1[8*c +: 8]);
		end
	end

	assign y_ge2             = y_s1 >= ycnt_t'(2);
	assign kinds[RES_INNER]  = y_ge2 && (x_s1 != '0);
	assign kinds[RES_RIM]    = y_ge2 && (x_s1 == X_LAST);
	assign kinds[RES_BOTTOM] = (y_s1 == '0) || (y_s1 == Y_LAST);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			kinds_s2 <= kinds;
			x8_s2    <= 8'(x_s1);
			y8_s2    <= 8'(y_s1);
			for (int c = 0; c < 3; c++) sum_s2[c] <= sum_c[c];
			blur_s2  <= x_s1 >= xcnt_t'(2);
			pass_s2  <= win_q[1];
			mid_s2   <= mid;
			cur_s2   <= cur_s1;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod[c]          = 25'(sum_s2[c]) * 25'(DIV_MUL);
			quot[8*c +: 8]   = prod[c][DIV_SH +: 8];
		end
	end

	assign push               = v_s2 && (kinds_s2 != '0);
	assign push_rec.kinds     = kinds_s2;
	assign push_rec.x         = x8_s2;
	assign push_rec.y         = y8_s2;
	assign push_rec.inner_pix = blur_s2 ? quot : pass_s2;
	assign push_rec.rim_pix   = mid_s2;
	assign push_rec.cur_pix   = cur_s2;

`ifndef SYNTHESIS
	a_no_line_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && v_s1) |-> (x_q != x_s1))
		else $error("line memory read and write hit the same column");
`endif

endmodule

// ----- sv/bbl_fifo.sv -----
// Record queue between the front and back ends.
module bbl_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bbl_pkg::rec_t  push_rec,
	input  logic           pop,
	output bbl_pkg::rec_t  head,
	output logic           not_empty,
	output bbl_pkg::qlvl_t level
);
	import bbl_pkg::*;

	rec_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	qlvl_t          cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_rec;
	end

	assign head      = mem_q[rd_q];
	assign not_empty = cnt_q != '0;
	assign level     = cnt_q;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != qlvl_t'(QDEPTH)))
		else $error("record queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("record queue underflow");
`endif

endmodule

// ----- sv/bbl_back.sv -----
// Back end: splits each record into its results and drives the output register.
module bbl_back (
	input  logic          clk,
	input  logic          arst_n,
	input  bbl_pkg::rec_t head,
	input  logic          not_empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_x,
	output logic [7:0]    out_y,
	output logic [7:0]    out_red,
	output logic [7:0]    out_green,
	output logic [7:0]    out_blue,
	output logic          last_of_run
);
	import bbl_pkg::*;

	logic [RES_N-1:0] done_q;
	logic [RES_N-1:0] rem;
	logic [RES_N-1:0] pick;
	logic             last;
	logic             load;
	logic             out_valid_q;
	logic [7:0]       nx;
	logic [7:0]       ny;
	pix_t             npix;
	logic [7:0]       x_q;
	logic [7:0]       y_q;
	pix_t             pix_q;
	logic             last_q;

	assign rem  = head.kinds & ~done_q;
	assign load = not_empty && (!out_valid_q || !out_stall);

	always_comb begin
		pick = '0;
		nx   = head.x;
		ny   = head.y;
		npix = head.cur_pix;
		priority if (rem[RES_INNER]) begin
			pick[RES_INNER] = 1'b1;
			nx   = head.x - 8'd1;
			ny   = head.y - 8'd1;
			npix = head.inner_pix;
		end else if (rem[RES_RIM]) begin
			pick[RES_RIM] = 1'b1;
			ny   = head.y - 8'd1;
			npix = head.rim_pix;
		end else begin
			pick[RES_BOTTOM] = 1'b1;
		end
	end

	assign last = (rem & ~pick) == '0;
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) done_q <= last ? '0 : (done_q | pick);
			if (load)            out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= nx;
			y_q    <= ny;
			pix_q  <= npix;
			last_q <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_x       = x_q;
	assign out_y       = y_q;
	assign out_red     = pix_q[23:16];
	assign out_green   = pix_q[15:8];
	assign out_blue    = pix_q[7:0];
	assign last_of_run = last_q;

`ifndef SYNTHESIS
	a_pick_pending: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ((pick & rem) == pick) && $onehot(pick))
		else $error("emitted a result kind not pending in the record");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for the 3x3 box blur: streams the top rows of a frame, checks every tagged result.
module tb_top;
	import bbl_pkg::*;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
	} blur_res_t;

	typedef enum logic [1:0] {FILL_RANDOM, FILL_PATCH, FILL_EXTREME} fill_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] red       = '0;
	logic [7:0] green     = '0;
	logic [7:0] blue      = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_x;
	logic [7:0] out_y;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       last_of_run;

	// Predictor state: two previous rows, the two previous columns, raster position
	pix_t line_above     [FRAME_WIDTH] = '{default: '0};
	pix_t line_two_above [FRAME_WIDTH] = '{default: '0};
	pix_t blur_window    [6]           = '{default: '0};
	int   col_at = 0;
	int   row_at = 0;

	blur_res_t pending_pixels [$];
	int        mismatches   = 0;
	int        results_seen = 0;
	int        pixels_sent  = 0;
	int        rx_hold      = 0;
	bit        tx_idle      = 1'b0;
	bit        rx_idle      = 1'b0;

	box_blur_three_by_three_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.last_of_run (last_of_run)
	);

	always #2 clk = ~clk;

	initial begin
		#6_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		// keep the log short when everything goes wrong
		if (mismatches <= 30)
			$display("MISMATCH: %s", what);
	endtask

	task automatic predict_blur_results(input pix_t cur);
		pix_t      top, mid, pix;
		pix_t      nb [9];
		blur_res_t outs [3];
		int        n, sum, ch, k;
		n = 0;
		top = line_two_above[col_at];
		mid = line_above[col_at];
		if (row_at == 0) begin
			outs[n] = {8'(col_at), 8'(row_at), cur, 1'b0};
			n++;
		end else if (row_at >= 2) begin
			if (col_at >= 1) begin
				if (col_at >= 2) begin
					nb = '{blur_window[3], blur_window[0], top,
					       blur_window[4], blur_window[1], mid,
					       blur_window[5], blur_window[2], cur};
					for (ch = 0; ch < 3; ch++) begin
						sum = 0;
						for (k = 0; k < 9; k++)
							sum += nb[k][8*ch +: 8];
						pix[8*ch +: 8] = 8'(sum / 9);
					end
				end else begin
					// left border of the row above passes through
					pix = blur_window[1];
				end
				outs[n] = {8'(col_at - 1), 8'(row_at - 1), pix, 1'b0};
				n++;
			end
			if (col_at == FRAME_WIDTH - 1) begin
				outs[n] = {8'(col_at), 8'(row_at - 1), mid, 1'b0};
				n++;
			end
			if (row_at == FRAME_HEIGHT - 1) begin
				outs[n] = {8'(col_at), 8'(row_at), cur, 1'b0};
				n++;
			end
		end
		for (k = 0; k < n; k++) begin
			outs[k].last = (k == n - 1);
			pending_pixels.push_back(outs[k]);
		end

		blur_window[3] = blur_window[0];
		blur_window[4] = blur_window[1];
		blur_window[5] = blur_window[2];
		blur_window[0] = top;
		blur_window[1] = mid;
		blur_window[2] = cur;
		line_two_above[col_at] = mid;
		line_above[col_at] = cur;

		if (col_at == FRAME_WIDTH - 1) begin
			col_at = 0;
			row_at = (row_at == FRAME_HEIGHT - 1) ? 0 : row_at + 1;
		end else begin
			col_at++;
		end
	endtask

	task automatic send_pixel(input pix_t p);
		int gap;
		gap = (tx_idle && $urandom_range(0, 3) != 0) ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{red, green, blue} <= p;
		do @(posedge clk); while (in_stall);
		predict_blur_results(p);
		pixels_sent++;
	endtask

	// Hold the input until every expected result has come out or the guard runs out
	task automatic wait_for_drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
			guard++;
		end while (pending_pixels.size() != 0 && guard < 50000);
	endtask

	// Send count pixels; pause before column pause_col when it comes up
	task automatic send_run(input fill_t fill, input int count, input int pause_col);
		pix_t p;
		int   k;
		for (k = 0; k < count; k++) begin
			case (fill)
				FILL_PATCH: begin
					if (col_at < 12)
						p = 24'hFFFFFF;
					else if (col_at < 24)
						p = 24'h000000;
					else
						p = pix_t'($urandom);
				end
				FILL_EXTREME: begin
					p = {($urandom_range(0, 1) ? 8'hFF : 8'h00),
					     ($urandom_range(0, 1) ? 8'hFF : 8'h00),
					     ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
				end
				default: p = pix_t'($urandom);
			endcase
			if (col_at == pause_col)
				wait_for_drain();
			send_pixel(p);
		end
	endtask

	task automatic test_directed_extremes();
		pix_t patterns [$];
		int   k;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		patterns = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
		             24'hAA55AA, 24'h55AA55, 24'h7F807F, 24'h80FF01};
		for (k = 0; k < 8; k++)
			patterns.push_back(24'h010101 << k);
		for (k = 0; k < 8; k++)
			patterns.push_back(~(24'h010101 << k));
		foreach (patterns[i])
			send_pixel(patterns[i]);
		send_run(FILL_EXTREME, 39, -1);
	endtask

	// Rest of the top row under gaps and stalls, with one full drain in the middle
	task automatic test_row_zero_stalls();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_run(FILL_RANDOM, FRAME_WIDTH - 64, 128);
	endtask

	// Second row only fills the line store and must stay silent
	task automatic test_line_fill();
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		send_run(FILL_PATCH, 104, -1);
	endtask

	always @(posedge clk) begin : result_check
		blur_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("result at (%0d,%0d) with nothing pending",
				                          out_x, out_y));
			end else begin
				want = pending_pixels.pop_front();
				if (out_x !== want.x)
					report_mismatch($sformatf("x got %0d want %0d", out_x, want.x));
				if (out_y !== want.y)
					report_mismatch($sformatf("y got %0d want %0d at x %0d",
					                          out_y, want.y, want.x));
				if (out_red !== want.r)
					report_mismatch($sformatf("red at (%0d,%0d) got %0d want %0d",
					                          want.x, want.y, out_red, want.r));
				if (out_green !== want.g)
					report_mismatch($sformatf("green at (%0d,%0d) got %0d want %0d",
					                          want.x, want.y, out_green, want.g));
				if (out_blue !== want.b)
					report_mismatch($sformatf("blue at (%0d,%0d) got %0d want %0d",
					                          want.x, want.y, out_blue, want.b));
				if (last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run at (%0d,%0d) got %b want %b",
					                          want.x, want.y, last_of_run, want.last));
			end
			rx_hold = rx_idle ? $urandom_range(0, 12) : 0;
		end else if (rx_hold > 0) begin
			rx_hold--;
		end
		out_stall <= (rx_hold > 0);
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_row_zero_stalls();
		test_line_fill();

		wait_for_drain();
		repeat (12) @(posedge clk);
		if (pending_pixels.size() != 0)
			report_mismatch($sformatf("%0d expected results never came out",
			                          pending_pixels.size()));

		$display("Sent %0d pixels: the top row with extreme values and a drain pause,",
		         pixels_sent);
		$display("then part of the silent second row; checked %0d results under gaps and stalls.",
		         results_seen);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/bbl_pkg.sv
sv/bbl_front.sv
sv/bbl_fifo.sv
sv/bbl_back.sv
sv/box_blur_three_by_three_top.sv
tb/sv/tb_top.sv
